FILE: src/bhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bhp_pkg;

  // Status codes of a result transaction
  localparam logic [2:0] ST_PARSING = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_FAILED  = 3'd2;
  localparam logic [2:0] ST_AFTER   = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_MAGIC     = 3'd1;
  localparam logic [2:0] ERR_WORD      = 3'd2;
  localparam logic [2:0] ERR_TAG       = 3'd3;
  localparam logic [2:0] ERR_NO_NUL    = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED = 3'd5;
  localparam logic [2:0] ERR_ZERO_LEN  = 3'd6;

  // Header constants
  localparam logic [7:0]  MAGIC_EVEN   = 8'h0F;
  localparam logic [7:0]  MAGIC_ODD    = 8'hF0;
  localparam logic [15:0] HEADER_WORD  = 16'h0001;
  localparam logic [7:0]  TAG_FIRST    = 8'h61;  // 'a'
  localparam logic [7:0]  TAG_LENGTH   = 8'h65;  // 'e'
  localparam logic [2:0]  STRING_COUNT = 3'd4;
  localparam logic [15:0] BLEN_BYTES   = 16'd4;

  localparam int unsigned           COUNT_W   = 19;
  localparam logic [COUNT_W-1:0]    COUNT_MAX = '1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } bhp_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [2:0]         error_code;
    logic [2:0]         string_field;
    logic [7:0]         string_byte;
    logic [31:0]        stream_len;
    logic [COUNT_W-1:0] hdr_byte_cnt;
  } bhp_result_t;

endpackage
`default_nettype wire

FILE: src/bhp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

FILE: src/bhp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bhp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  error_code;
  logic [2:0]  string_field;
  logic [7:0]  string_byte;
  logic [31:0] stream_len;
  logic [18:0] hdr_byte_cnt;

  modport source (output valid, output status, output error_code, output string_field,
                  output string_byte, output stream_len, output hdr_byte_cnt,
                  input ready);
  modport sink (input valid, input status, input error_code, input string_field,
                input string_byte, input stream_len, input hdr_byte_cnt,
                output ready);
endinterface
`default_nettype wire

FILE: src/bhp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
module bhp_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                advance,
  input  wire bhp_pkg::bhp_item_t  item,
  output bhp_pkg::bhp_result_t     result
);
  import bhp_pkg::*;

  localparam logic [3:0] PH_MLEN_HI = 4'd0;
  localparam logic [3:0] PH_MLEN_LO = 4'd1;
  localparam logic [3:0] PH_MAGIC   = 4'd2;
  localparam logic [3:0] PH_SKIP    = 4'd3;
  localparam logic [3:0] PH_WORD_HI = 4'd4;
  localparam logic [3:0] PH_WORD_LO = 4'd5;
  localparam logic [3:0] PH_TAG     = 4'd6;
  localparam logic [3:0] PH_SLEN_HI = 4'd7;
  localparam logic [3:0] PH_SLEN_LO = 4'd8;
  localparam logic [3:0] PH_STRING  = 4'd9;
  localparam logic [3:0] PH_ETAG    = 4'd10;
  localparam logic [3:0] PH_BLEN    = 4'd11;
  localparam logic [3:0] PH_DONE    = 4'd12;
  localparam logic [3:0] PH_FAIL    = 4'd13;

  logic [3:0]         phase_r, phase_nxt;
  logic [15:0]        remain_r, remain_nxt;
  logic               magic_odd_r, magic_odd_nxt;
  logic [31:0]        shift_r, shift_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [2:0]         cur_str_r, cur_str_nxt;
  logic [2:0]         held_err_r, held_err_nxt;

  logic [15:0] word_val;
  logic [15:0] remain_dec;
  logic [7:0]  b;

  assign b          = item.data_byte;
  assign word_val   = {shift_r[7:0], b};
  assign remain_dec = remain_r - 16'd1;

  always_comb begin
    phase_nxt     = phase_r;
    remain_nxt    = remain_r;
    magic_odd_nxt = magic_odd_r;
    shift_nxt     = shift_r;
    count_nxt     = count_r;
    cur_str_nxt   = cur_str_r;
    held_err_nxt  = held_err_r;
    result        = '0;

    if (phase_r == PH_DONE) begin
      result.status = ST_AFTER;
    end else if (phase_r == PH_FAIL) begin
      result.status     = ST_IGNORED;
      result.error_code = held_err_r;
    end else begin
      if (count_r != COUNT_MAX) begin
        count_nxt = count_r + 1'b1;
      end
      case (phase_r)
        PH_MLEN_HI, PH_WORD_HI, PH_SLEN_HI: begin
          shift_nxt = {24'd0, b};
          phase_nxt = phase_r + 4'd1;
        end
        PH_MLEN_LO: begin
          if (word_val == 16'd0) begin
            result.status     = ST_FAILED;
            result.error_code = ERR_ZERO_LEN;
          end else begin
            remain_nxt    = word_val - 16'd1;
            magic_odd_nxt = 1'b0;
            phase_nxt     = (word_val == 16'd1) ? PH_SKIP : PH_MAGIC;
          end
        end
        PH_MAGIC: begin
          if (b != (magic_odd_r ? MAGIC_ODD : MAGIC_EVEN)) begin
            result.status     = ST_FAILED;
            result.error_code = ERR_MAGIC;
          end else begin
            magic_odd_nxt = ~magic_odd_r;
            remain_nxt    = remain_dec;
            if (remain_dec == 16'd0) begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          phase_nxt = PH_WORD_HI;
        end
        PH_WORD_LO: begin
          if (word_val != HEADER_WORD) begin
            result.status     = ST_FAILED;
            result.error_code = ERR_WORD;
          end else begin
            cur_str_nxt = '0;
            phase_nxt   = PH_TAG;
          end
        end
        PH_TAG: begin
          if (cur_str_r >= STRING_COUNT || b != (TAG_FIRST + {5'd0, cur_str_r})) begin
            result.status     = ST_FAILED;
            result.error_code = ERR_TAG;
          end else begin
            cur_str_nxt = cur_str_r + 3'd1;
            phase_nxt   = PH_SLEN_HI;
          end
        end
        PH_SLEN_LO: begin
          if (word_val == 16'd0) begin
            result.status     = ST_FAILED;
            result.error_code = ERR_ZERO_LEN;
          end else begin
            remain_nxt = word_val;
            phase_nxt  = PH_STRING;
          end
        end
        PH_STRING: begin
          remain_nxt = remain_dec;
          if (remain_dec == 16'd0 && b != 8'd0) begin
            result.status     = ST_FAILED;
            result.error_code = ERR_NO_NUL;
          end else begin
            result.string_field = cur_str_r;
            result.string_byte  = b;
            if (remain_dec == 16'd0) begin
              phase_nxt = (cur_str_r >= STRING_COUNT) ? PH_ETAG : PH_TAG;
            end
          end
        end
        PH_ETAG: begin
          if (b != TAG_LENGTH) begin
            result.status     = ST_FAILED;
            result.error_code = ERR_TAG;
          end else begin
            remain_nxt = BLEN_BYTES;
            shift_nxt  = '0;
            phase_nxt  = PH_BLEN;
          end
        end
        PH_BLEN: begin
          shift_nxt  = {shift_r[23:0], b};
          remain_nxt = remain_dec;
          if (remain_dec == 16'd0) begin
            result.status       = ST_DONE;
            result.stream_len   = {shift_r[23:0], b};
            result.hdr_byte_cnt = count_nxt;
            phase_nxt           = PH_DONE;
          end
        end
        default: begin
          phase_nxt = PH_FAIL;
        end
      endcase
      if (result.status == ST_PARSING && item.last_byte) begin
        result.status     = ST_FAILED;
        result.error_code = ERR_TRUNCATED;
      end
      if (result.status == ST_FAILED) begin
        held_err_nxt = result.error_code;
        phase_nxt    = PH_FAIL;
      end
    end

    // End of buffer: start over for the next file
    if (item.last_byte) begin
      phase_nxt     = PH_MLEN_HI;
      remain_nxt    = '0;
      magic_odd_nxt = 1'b0;
      shift_nxt     = '0;
      count_nxt     = '0;
      cur_str_nxt   = '0;
      held_err_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MLEN_HI;
      remain_r    <= '0;
      magic_odd_r <= 1'b0;
      shift_r     <= '0;
      count_r     <= '0;
      cur_str_r   <= '0;
      held_err_r  <= '0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      remain_r    <= remain_nxt;
      magic_odd_r <= magic_odd_nxt;
      shift_r     <= shift_nxt;
      count_r     <= count_nxt;
      cur_str_r   <= cur_str_nxt;
      held_err_r  <= held_err_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: src/bitstream_header_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// Byte-serial parser for an FPGA configuration-file header. Feed the file one
// byte per transaction on in_chan, with last_byte marking the final byte of the
// buffer; every input transaction yields exactly one result transaction on
// out_chan. A result carries the parse status, an error code, the string byte
// with its field number (design, part, date, time) while tagged strings pass,
// and, on the byte that completes the header, the bitstream length and the
// header byte count. After completion or failure the remaining bytes are
// acknowledged with status 3 or 4 until last_byte, which returns the parser to
// its start state. Throughput is one byte per clock while no result waits
// downstream: the parser state is updated by a single short combinational step
// for each byte. A byte passes an input register and then a result register
// before its result turns valid. A result waiting downstream stalls the input
// only once the input register also holds a byte.
module bitstream_header_parser (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bhp_in_if.sink      in_chan,
  bhp_out_if.source   out_chan
);
  import bhp_pkg::*;

  // Input register
  logic       in_valid_r, in_valid_nxt;
  bhp_item_t  in_item_r;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  bhp_result_t out_res_r;

  bhp_result_t step_res;
  logic        advance;

  // Move the held byte into the parser when the result register is free or its result is being taken
  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_chan.ready) begin
      in_valid_nxt = in_chan.valid;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture on transaction, hold otherwise
  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_item_r.data_byte <= in_chan.data_byte;
      in_item_r.last_byte <= in_chan.last_byte;
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  bhp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .result  (step_res)
  );

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_res_r.status;
  assign out_chan.error_code   = out_res_r.error_code;
  assign out_chan.string_field = out_res_r.string_field;
  assign out_chan.string_byte  = out_res_r.string_byte;
  assign out_chan.stream_len   = out_res_r.stream_len;
  assign out_chan.hdr_byte_cnt = out_res_r.hdr_byte_cnt;

  // Input only stalls when both registers are full and the sink holds off
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (in_valid_r && out_valid_r && !out_chan.ready))
    else $error("input stalled without a full pipeline");

  // A failure always carries a nonzero code
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.status == ST_FAILED || out_res_r.status == ST_IGNORED))
      |-> (out_res_r.error_code != ERR_NONE))
    else $error("failure reported without an error code");

  // String bytes only appear while parsing, or on a string byte that ends the buffer
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.string_field != 3'd0)
      |-> (out_res_r.status == ST_PARSING ||
           (out_res_r.status == ST_FAILED && out_res_r.error_code == ERR_TRUNCATED)))
    else $error("string byte outside of parsing");

  // A completed header always has a nonzero byte count
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status == ST_DONE) |-> (out_res_r.hdr_byte_cnt != '0))
    else $error("completed header with zero length");
endmodule
`default_nettype wire
